### rtl/core/tacc_pkg.sv
// Shared types and constants for the toroidal activation cache table.
package tacc_pkg;

	// Command codes carried by an input transaction
	typedef enum logic [1:0] {
		CMD_QUERY    = 2'd0,
		CMD_ACTIVATE = 2'd1,
		CMD_MARK     = 2'd2,
		CMD_CLEAR    = 2'd3
	} tacc_cmd_t;

	// Two-bit entry states held in the table memory
	localparam logic [1:0] ENT_EMPTY     = 2'd0;
	localparam logic [1:0] ENT_ACTIVATED = 2'd1;
	localparam logic [1:0] ENT_CACHED    = 2'd2;

	// Position field width covers the largest supported side (256)
	localparam int POS_W = 8;
	// Coordinate width after sign extension and a +/-1 offset, room for +/- side
	localparam int COORD_EXT_W = 10;

	// Classified operation passed from the front end to the back end.
	// Index 0 is coordinate-1, index 1 the coordinate itself, index 2 coordinate+1.
	typedef struct packed {
		tacc_cmd_t               cmd;
		logic [2:0][POS_W-1:0]   pu;
		logic [2:0][POS_W-1:0]   pv;
	} tacc_op_t;

	// Back end status seen by the front end
	typedef struct packed {
		logic init_busy;
	} tacc_bstat_t;

	// Back end sequencer states
	typedef enum logic [3:0] {
		BS_INIT,
		BS_IDLE,
		BS_RD,
		BS_RD_WAIT,
		BS_ACT_RD,
		BS_ACT_WR,
		BS_MARK,
		BS_CLR,
		BS_OUT
	} tacc_bstate_t;

endpackage

### rtl/core/tacc_ram.sv
// Generic single-port RAM with registered read data.
module tacc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One access per cycle: write, or read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/tacc_fifo.sv
// Short operation queue between the front end and the back end.
module tacc_fifo #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tacc_pkg::tacc_op_t wdata,
	output logic              full,
	input  logic              pop,
	output tacc_pkg::tacc_op_t rdata,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tacc_pkg::tacc_op_t buf_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = buf_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### rtl/core/tacc_front.sv
// Front end: side length register, input acceptance and coordinate wrapping.
module tacc_front #(
	parameter int MAX_SIDE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// side length write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [6:0]            table_size,
	// command input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            command,
	input  logic signed [7:0]     coord_u,
	input  logic signed [7:0]     coord_v,
	// queue side
	input  tacc_pkg::tacc_bstat_t bstat,
	input  logic                  q_full,
	output logic                  q_push,
	output tacc_pkg::tacc_op_t    q_op
);

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int PW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int CW = tacc_pkg::COORD_EXT_W;
	localparam int SIZE_RST = (MAX_SIDE < 64) ? MAX_SIDE : 64;

	logic [SW-1:0] size_q;
	logic signed [CW-1:0] cu;
	logic signed [CW-1:0] cv;

	// Zero maps to one, anything above the maximum saturates
	function automatic logic [SW-1:0] clamp_size(input logic [6:0] v);
		if (v == 7'd0) begin
			return SW'(1);
		end else if (int'(v) > MAX_SIDE) begin
			return SW'(MAX_SIDE);
		end else begin
			return SW'(v);
		end
	endfunction

	// One add or subtract of the side, then anything still out of range maps to 0
	function automatic logic [PW-1:0] wrap_pos(input logic signed [CW-1:0] c,
			input logic [SW-1:0] s);
		logic signed [CW-1:0] se;
		logic signed [CW-1:0] t;
		se = $signed(CW'(s));
		if (c >= se) begin
			t = c - se;
		end else if (c < 0) begin
			t = c + se;
		end else begin
			t = c;
		end
		if (t >= 0 && t < se) begin
			return PW'(t);
		end else begin
			return '0;
		end
	endfunction

	// Side length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SW'(SIZE_RST);
		end else if (cfg_valid) begin
			size_q <= clamp_size(table_size);
		end
	end

	assign cfg_ready = 1'b1;

	// Input handshake: hold off during the reset clear and when the queue is full
	assign in_stall = bstat.init_busy || q_full;
	assign q_push   = in_valid && !in_stall;

	// Classify and wrap the neighbourhood coordinates
	assign cu = CW'(coord_u);
	assign cv = CW'(coord_v);

	always_comb begin
		q_op.cmd   = tacc_pkg::tacc_cmd_t'(command);
		q_op.pu[0] = tacc_pkg::POS_W'(wrap_pos(cu - CW'(1), size_q));
		q_op.pu[1] = tacc_pkg::POS_W'(wrap_pos(cu, size_q));
		q_op.pu[2] = tacc_pkg::POS_W'(wrap_pos(cu + CW'(1), size_q));
		q_op.pv[0] = tacc_pkg::POS_W'(wrap_pos(cv - CW'(1), size_q));
		q_op.pv[1] = tacc_pkg::POS_W'(wrap_pos(cv, size_q));
		q_op.pv[2] = tacc_pkg::POS_W'(wrap_pos(cv + CW'(1), size_q));
	end

endmodule

### rtl/core/tacc_back.sv
// Back end: table memory sequencer and result register.
module tacc_back #(
	parameter int MAX_SIDE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// queue side
	input  logic                  q_empty,
	input  tacc_pkg::tacc_op_t    q_op,
	output logic                  q_pop,
	output tacc_pkg::tacc_bstat_t bstat,
	// result output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  is_activated,
	output logic                  is_cached
);

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	tacc_pkg::tacc_bstate_t state_q, state_d;
	tacc_pkg::tacc_op_t     op_q;
	logic [1:0]    i_q, j_q;
	logic [AW-1:0] clr_q;
	logic          res_act_q, res_cch_q;
	logic          out_valid_q, is_act_q, is_cch_q;

	logic          ram_en, ram_we;
	logic [AW-1:0] ram_addr;
	logic [1:0]    ram_wdata;
	logic [1:0]    ram_rdata;
	logic          out_load;
	logic          clr_last;
	logic          act_center;
	logic          act_last;
	logic [AW-1:0] center_addr;
	logic [AW-1:0] nbr_addr;

	// Entry (u, v) lives at u * MAX_SIDE + v
	function automatic logic [AW-1:0] cell_addr(input logic [PW-1:0] u,
			input logic [PW-1:0] v);
		return AW'(u) * AW'(MAX_SIDE) + AW'(v);
	endfunction

	tacc_ram #(
		.WIDTH(2),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign center_addr = cell_addr(op_q.pu[1][PW-1:0], op_q.pv[1][PW-1:0]);
	assign nbr_addr    = cell_addr(op_q.pu[i_q][PW-1:0], op_q.pv[j_q][PW-1:0]);
	assign clr_last    = (clr_q == AW'(DEPTH - 1));
	assign act_center  = (i_q == 2'd1) && (j_q == 2'd1);
	assign act_last    = (i_q == 2'd2) && (j_q == 2'd2);
	assign bstat.init_busy = (state_q == tacc_pkg::BS_INIT);

	// Next state, memory control and queue pop
	always_comb begin
		state_d   = state_q;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = center_addr;
		ram_wdata = tacc_pkg::ENT_EMPTY;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			tacc_pkg::BS_INIT: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (clr_last) begin
					state_d = tacc_pkg::BS_IDLE;
				end
			end
			tacc_pkg::BS_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					unique case (q_op.cmd)
						tacc_pkg::CMD_QUERY:    state_d = tacc_pkg::BS_RD;
						tacc_pkg::CMD_ACTIVATE: state_d = tacc_pkg::BS_ACT_RD;
						tacc_pkg::CMD_MARK:     state_d = tacc_pkg::BS_MARK;
						tacc_pkg::CMD_CLEAR:    state_d = tacc_pkg::BS_CLR;
						default:                state_d = tacc_pkg::BS_IDLE;
					endcase
				end
			end
			tacc_pkg::BS_RD: begin
				ram_en  = 1'b1;
				state_d = tacc_pkg::BS_RD_WAIT;
			end
			tacc_pkg::BS_RD_WAIT: begin
				state_d = tacc_pkg::BS_OUT;
			end
			tacc_pkg::BS_ACT_RD: begin
				ram_en   = 1'b1;
				ram_addr = nbr_addr;
				state_d  = tacc_pkg::BS_ACT_WR;
			end
			tacc_pkg::BS_ACT_WR: begin
				// cached entries stay cached
				ram_en    = (ram_rdata != tacc_pkg::ENT_CACHED);
				ram_we    = 1'b1;
				ram_addr  = nbr_addr;
				ram_wdata = tacc_pkg::ENT_ACTIVATED;
				state_d   = act_last ? tacc_pkg::BS_OUT : tacc_pkg::BS_ACT_RD;
			end
			tacc_pkg::BS_MARK: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = tacc_pkg::ENT_CACHED;
				state_d   = tacc_pkg::BS_OUT;
			end
			tacc_pkg::BS_CLR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (clr_last) begin
					state_d = tacc_pkg::BS_OUT;
				end
			end
			tacc_pkg::BS_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = tacc_pkg::BS_IDLE;
				end
			end
			default: state_d = tacc_pkg::BS_IDLE;
		endcase
	end

	// State, neighbourhood and sweep counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tacc_pkg::BS_INIT;
			i_q         <= '0;
			j_q         <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tacc_pkg::BS_IDLE) begin
				i_q   <= '0;
				j_q   <= '0;
				clr_q <= '0;
			end else if (state_q == tacc_pkg::BS_ACT_WR) begin
				if (j_q == 2'd2) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end else if (state_q == tacc_pkg::BS_INIT || state_q == tacc_pkg::BS_CLR) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operation, pending result and output payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
		end
		case (state_q)
			tacc_pkg::BS_RD_WAIT: begin
				res_act_q <= (ram_rdata == tacc_pkg::ENT_ACTIVATED);
				res_cch_q <= (ram_rdata == tacc_pkg::ENT_CACHED);
			end
			tacc_pkg::BS_ACT_WR: begin
				// activate leaves the center activated unless it was cached
				if (act_center) begin
					res_act_q <= (ram_rdata != tacc_pkg::ENT_CACHED);
					res_cch_q <= (ram_rdata == tacc_pkg::ENT_CACHED);
				end
			end
			tacc_pkg::BS_MARK: begin
				res_act_q <= 1'b0;
				res_cch_q <= 1'b1;
			end
			tacc_pkg::BS_CLR: begin
				res_act_q <= 1'b0;
				res_cch_q <= 1'b0;
			end
			default: ;
		endcase
		if (out_load) begin
			is_act_q <= res_act_q;
			is_cch_q <= res_cch_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_activated = is_act_q;
	assign is_cached    = is_cch_q;

endmodule

### rtl/core/toroidal_activation_cache_table_top.sv
// Top level of the toroidal activation cache table.
// Usage:
//   Command channel (in_valid/in_stall, command, coord_u, coord_v): a transaction is
//   taken when in_valid is high and in_stall low. Coordinates are signed and wrap
//   once around the side length currently in use; values still out of range map to 0.
//   Result channel (out_valid/out_stall, is_activated, is_cached): one transaction
//   per command, in command order, held stable while out_stall is high.
//   Side length port (cfg_valid/cfg_ready, table_size): write only while idle;
//   0 reads as 1, values above MAX_SIDE saturate. Stored entries are kept.
// Execution:
//   Query reads the center entry, mark cached writes it, activate makes nine read and
//   write pairs on the single-port table memory, clear writes the whole table (one
//   entry written per cycle). One command is executed at a time; a two-entry queue
//   keeps taking commands while the back end works.
// Reset:
//   After arst_n is released the table memory is cleared one entry per cycle, with
//   in_stall held high; side length resets to MAX_SIDE or 64, whichever is smaller.
//   A stalled result holds the back end after the current command; the queue
//   then fills and in_stall rises.
module toroidal_activation_cache_table_top #(
	parameter int MAX_SIDE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        table_size,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic signed [7:0] coord_u,
	input  logic signed [7:0] coord_v,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              is_activated,
	output logic              is_cached
);

	localparam int QUEUE_DEPTH = 2;

	tacc_pkg::tacc_op_t    push_op;
	tacc_pkg::tacc_op_t    head_op;
	tacc_pkg::tacc_bstat_t bstat;
	logic                  q_push, q_pop, q_full, q_empty;

	// Front end: accepts and classifies commands
	tacc_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.table_size(table_size),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.coord_u   (coord_u),
		.coord_v   (coord_v),
		.bstat     (bstat),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (push_op)
	);

	// Operation queue
	tacc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (push_op),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (head_op),
		.empty (q_empty)
	);

	// Back end: table memory and results
	tacc_back #(
		.MAX_SIDE(MAX_SIDE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_op        (head_op),
		.q_pop       (q_pop),
		.bstat       (bstat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_activated(is_activated),
		.is_cached   (is_cached)
	);

endmodule
